FILE: hw/rtl/tcc_pkg.sv
package tcc_pkg;

    // Character codes with a control meaning.
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;

    // Register indexes on the configuration channel.
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [1:0] REG_TEXT_COLOR   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0]  COLUMN_COUNT_RESET = 8'd128;
    localparam logic [7:0]  ROW_COUNT_RESET    = 8'd48;
    localparam logic [23:0] TEXT_COLOR_RESET   = 24'hFF_FFFF;
    localparam logic [23:0] COLOR_BLACK        = 24'h00_0000;

    // Largest cursor row value.
    localparam logic [7:0] ROW_MAX = 8'd255;

    // Cell command carried on the result channel.
    typedef enum logic [1:0] {
        ACT_DRAW   = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_SCROLL = 2'd2
    } action_t;

endpackage

FILE: hw/rtl/text_console_cursor_controller.sv
// Text console cursor controller. Each input beat carries one character
// code in s_tdata, with s_tlast marking the final character of a write.
// The block keeps the cursor column and row and emits cell commands on
// the m_ side: draw (with the configured text color), clear (for
// backspace) and scroll up one line, the command code in m_tuser and
// m_tlast set on the last command caused by a character. Newlines,
// a backspace at the origin and discarded characters give no command.
// A character sits in an input register and its commands are formed in
// one pass into the output register, so one character completes per
// cycle unless the result side stalls; a printable character that has to
// scroll the screen sends its scroll command in one pass and its draw
// command in a later one, as both share the single output register.
// Configuration writes are taken at any time (cfg_ready is always high)
// but are meant to be made only while the block is idle.
module text_console_cursor_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_code
    input  logic                  s_tlast,   // write_end
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] cell_column, [15:8] cell_row, [23:16] glyph_code, [47:24] draw_color
    output logic [47:0]           m_tdata,
    output tcc_pkg::action_t      m_tuser,   // [1:0] action
    output logic                  m_tlast,   // last
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [23:0]           cfg_data
);
    import tcc_pkg::*;

    // Configuration registers.
    logic [7:0]  column_count_reg;
    logic [7:0]  row_count_reg;
    logic [23:0] text_color_reg;

    // Cursor state.
    logic [7:0]  cursor_column_reg, cursor_column_next;
    logic [7:0]  cursor_row_reg, cursor_row_next;
    logic        discard_rest_reg, discard_rest_next;

    // Input register.
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_end_reg;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    action_t     out_action_reg, out_action_next;
    logic [7:0]  out_column_reg, out_column_next;
    logic [7:0]  out_row_reg, out_row_next;
    logic [7:0]  out_glyph_reg, out_glyph_next;
    logic [23:0] out_color_reg, out_color_next;
    logic        out_last_reg, out_last_next;

    // Working values for the held character.
    logic [7:0]  cols;
    logic [7:0]  rows;
    logic        out_free;
    logic        emit;
    logic        done;
    logic        wrap;
    logic [7:0]  wrap_column;
    logic [7:0]  wrap_row;
    logic [7:0]  back_column;
    logic [7:0]  back_row;
    logic        s_fire;

    assign cols     = (column_count_reg == 8'd0) ? 8'd1 : column_count_reg;
    assign rows     = (row_count_reg == 8'd0) ? 8'd1 : row_count_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Printable wrap at the column limit.
    assign wrap        = (cursor_column_reg >= cols);
    assign wrap_column = wrap ? 8'd0 : cursor_column_reg;
    assign wrap_row    = (wrap && (cursor_row_reg < ROW_MAX)) ? cursor_row_reg + 8'd1
                                                              : cursor_row_reg;

    // Backspace step, wrapping to the end of the previous row.
    assign back_row    = (cursor_column_reg == 8'd0) ? cursor_row_reg - 8'd1 : cursor_row_reg;
    assign back_column = (cursor_column_reg == 8'd0) ? cols - 8'd1
                                                     : cursor_column_reg - 8'd1;

    // Command decode for the character in the input register.
    always_comb
    begin
        cursor_column_next = cursor_column_reg;
        cursor_row_next    = cursor_row_reg;
        discard_rest_next  = discard_rest_reg;
        emit               = 1'b0;
        done               = 1'b0;
        out_action_next    = out_action_reg;
        out_column_next    = out_column_reg;
        out_row_next       = out_row_reg;
        out_glyph_next     = out_glyph_reg;
        out_color_next     = out_color_reg;
        out_last_next      = out_last_reg;

        if (in_valid_reg)
        begin
            priority if (discard_rest_reg)
            begin
                // Rest of a write after a backspace at the origin.
                done = 1'b1;
                if (in_end_reg)
                begin
                    discard_rest_next = 1'b0;
                end
            end
            else if (in_char_reg == CODE_BACKSPACE)
            begin
                if ((cursor_column_reg == 8'd0) && (cursor_row_reg == 8'd0))
                begin
                    done              = 1'b1;
                    discard_rest_next = !in_end_reg;
                end
                else if (out_free)
                begin
                    done               = 1'b1;
                    emit               = 1'b1;
                    cursor_column_next = back_column;
                    cursor_row_next    = back_row;
                    out_action_next    = ACT_CLEAR;
                    out_column_next    = back_column;
                    out_row_next       = back_row;
                    out_glyph_next     = 8'd0;
                    out_color_next     = COLOR_BLACK;
                    out_last_next      = 1'b1;
                end
            end
            else if (in_char_reg == CODE_NEWLINE)
            begin
                done               = 1'b1;
                cursor_column_next = 8'd0;
                cursor_row_next    = (cursor_row_reg >= rows) ? rows : cursor_row_reg + 8'd1;
            end
            else if (out_free)
            begin
                emit               = 1'b1;
                cursor_column_next = wrap_column;
                if (wrap_row >= rows)
                begin
                    // Scroll first; the character stays in the input register and draws in a later pass.
                    cursor_row_next = rows - 8'd1;
                    out_action_next = ACT_SCROLL;
                    out_column_next = 8'd0;
                    out_row_next    = 8'd0;
                    out_glyph_next  = 8'd0;
                    out_color_next  = COLOR_BLACK;
                    out_last_next   = 1'b0;
                end
                else
                begin
                    done               = 1'b1;
                    cursor_column_next = wrap_column + 8'd1;
                    cursor_row_next    = wrap_row;
                    out_action_next    = ACT_DRAW;
                    out_column_next    = wrap_column;
                    out_row_next       = wrap_row;
                    out_glyph_next     = in_char_reg;
                    out_color_next     = text_color_reg;
                    out_last_next      = 1'b1;
                end
            end
        end
    end

    // Handshake control for both stages.
    assign s_tready = !in_valid_reg || done;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (done)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            cursor_column_reg <= 8'd0;
            cursor_row_reg    <= 8'd0;
            discard_rest_reg  <= 1'b0;
            column_count_reg  <= COLUMN_COUNT_RESET;
            row_count_reg     <= ROW_COUNT_RESET;
            text_color_reg    <= TEXT_COLOR_RESET;
        end
        else
        begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            cursor_column_reg <= cursor_column_next;
            cursor_row_reg    <= cursor_row_next;
            discard_rest_reg  <= discard_rest_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_COLUMN_COUNT: column_count_reg <= cfg_data[7:0];
                    REG_ROW_COUNT:    row_count_reg    <= cfg_data[7:0];
                    REG_TEXT_COLOR:   text_color_reg   <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (emit)
        begin
            out_action_reg <= out_action_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
            out_glyph_reg  <= out_glyph_next;
            out_color_reg  <= out_color_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_color_reg, out_glyph_reg, out_row_reg, out_column_reg};
    assign m_tuser   = out_action_reg;
    assign m_tlast   = out_last_reg;

endmodule

FILE: tb/tb_text_console_cursor_controller.sv
module tb_text_console_cursor_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    // Write to an index past the register list; the block must ignore it.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200_000;

    typedef struct packed {
        action_t     act;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  glyph;
        logic [23:0] color;
        logic        last;
    } cell_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [47:0] m_tdata;
    action_t     m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_COLUMN_COUNT;
    logic [23:0] cfg_data = 24'd0;

    // Shadow of the block: registers, cursor and the discard flag.
    logic [7:0]  column_count = COLUMN_COUNT_RESET;
    logic [7:0]  row_count = ROW_COUNT_RESET;
    logic [23:0] text_color = TEXT_COLOR_RESET;
    logic [7:0]  cur_col = 8'd0;
    logic [7:0]  cur_row = 8'd0;
    logic        discard_rest = 1'b0;

    cell_cmd_t cell_cmd_q[$];

    int  mismatches = 0;
    int  chars_sent = 0;
    int  live_chars = 0;
    int  cmds_checked = 0;
    int  reg_writes = 0;
    int  cycle_count = 0;
    bit  idle_en = 1'b1;
    int  hold_len = 0;
    int  hold_req = 0;
    int  hold_ack = 0;
    int  stall_left = 0;

    text_console_cursor_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d commands still expected.",
                     cycle_count, cell_cmd_q.size());
            $display("FAIL text_console_cursor_controller");
            $finish;
        end
    end

    // Result side ready: random stall bursts, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            stall_left = hold_len;
        end
        else if (stall_left == 0 && idle_en && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 4);
        end
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare every result beat with the oldest expected command.
    always @(posedge clk)
    begin
        cell_cmd_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cell_cmd_q.size() == 0)
            begin
                $display("%0t: command with none expected, expected nothing, actual %0d %h %b",
                         $time, m_tuser, m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                want = cell_cmd_q.pop_front();
                check_field("action", 24'(want.act), 24'(m_tuser));
                check_field("cell_column", 24'(want.col), 24'(m_tdata[7:0]));
                check_field("cell_row", 24'(want.row), 24'(m_tdata[15:8]));
                check_field("glyph_code", 24'(want.glyph), 24'(m_tdata[23:16]));
                check_field("draw_color", want.color, m_tdata[47:24]);
                check_field("last", 24'(want.last), 24'(m_tlast));
                cmds_checked++;
            end
        end
    end

    // Advance the shadow cursor for one accepted character and queue its commands.
    task automatic predict_cell_cmds(input logic [7:0] code, input logic end_flag);
        int        cols;
        int        rows;
        int        n;
        cell_cmd_t cmds[2];
        cols = (column_count == 8'd0) ? 1 : int'(column_count);
        rows = (row_count == 8'd0) ? 1 : int'(row_count);
        n = 0;
        chars_sent++;
        if (discard_rest)
        begin
            if (end_flag)
                discard_rest = 1'b0;
            return;
        end
        live_chars++;
        if (code == CODE_BACKSPACE)
        begin
            // At the origin nothing is cleared; the rest of the write may be dropped.
            if (cur_col == 8'd0 && cur_row == 8'd0)
            begin
                discard_rest = !end_flag;
                return;
            end
            if (cur_col == 8'd0)
            begin
                cur_row = cur_row - 8'd1;
                cur_col = 8'(cols);
            end
            cur_col = cur_col - 8'd1;
            cmds[n] = '{ACT_CLEAR, cur_col, cur_row, 8'd0, COLOR_BLACK, 1'b0};
            n++;
        end
        else if (code == CODE_NEWLINE)
        begin
            cur_row = (cur_row >= rows) ? 8'(rows) : cur_row + 8'd1;
            cur_col = 8'd0;
        end
        else
        begin
            if (cur_col >= cols)
            begin
                if (cur_row < ROW_MAX)
                    cur_row = cur_row + 8'd1;
                cur_col = 8'd0;
            end
            if (cur_row >= rows)
            begin
                cmds[n] = '{ACT_SCROLL, 8'd0, 8'd0, 8'd0, COLOR_BLACK, 1'b0};
                n++;
                cur_row = 8'(rows - 1);
            end
            cmds[n] = '{ACT_DRAW, cur_col, cur_row, code, text_color, 1'b0};
            n++;
            cur_col = cur_col + 8'd1;
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                cmds[i].last = 1'b1;
            cell_cmd_q.push_back(cmds[i]);
        end
    endtask

    // Offer one character beat, with an optional random gap in front of it.
    task automatic send_char(input logic [7:0] code, input logic end_flag);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= code;
        s_tlast <= end_flag;
        do @(posedge clk); while (!s_tready);
        predict_cell_cmds(code, end_flag);
    endtask

    // Stop offering and wait until every expected command is out and the block is quiet.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (cell_cmd_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            REG_COLUMN_COUNT: column_count = value[7:0];
            REG_ROW_COUNT:    row_count = value[7:0];
            REG_TEXT_COLOR:   text_color = value;
            default:          ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Counts carry random upper bits, which the block must drop.
    task automatic set_screen(input int cols, input int rows, input logic [23:0] color);
        write_reg(REG_COLUMN_COUNT, {16'($urandom), 8'(cols)});
        write_reg(REG_ROW_COUNT, {16'($urandom), 8'(rows)});
        write_reg(REG_TEXT_COLOR, color);
    endtask

    function automatic logic [7:0] random_glyph();
        logic [7:0] g;
        do g = 8'($urandom_range(0, 255));
        while (g == CODE_BACKSPACE || g == CODE_NEWLINE);
        return g;
    endfunction

    function automatic logic [7:0] random_char();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 14)
            return CODE_BACKSPACE;
        else if (roll < 24)
            return CODE_NEWLINE;
        return 8'($urandom_range(0, 255));
    endfunction

    // One write request: mostly mixed text, sometimes a run of backspaces.
    task automatic send_write(input int len);
        bit erase;
        erase = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++)
            send_char(erase ? CODE_BACKSPACE : random_char(), i == len - 1);
    endtask

    // Random text until the given number of characters has been acted on.
    task automatic run_text(input int target);
        int stop;
        stop = live_chars + target;
        while (live_chars < stop)
        begin
            if ($urandom_range(0, 9) == 0)
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                send_write($urandom_range(1, 12));
        end
    endtask

    // Origin backspace, discarding, code extremes, wrap, scroll and row saturation.
    task automatic test_directed();
        send_char(CODE_BACKSPACE, 1'b1);
        send_char(CODE_BACKSPACE, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CODE_NEWLINE, 1'b0);
        send_char(CODE_BACKSPACE, 1'b1);
        wait_idle();
        set_screen(2, 1, 24'($urandom));
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h63, 1'b0);
        send_char(CODE_NEWLINE, 1'b0);
        send_char(CODE_NEWLINE, 1'b0);
        send_char(CODE_BACKSPACE, 1'b0);
        send_char(CODE_BACKSPACE, 1'b0);
        send_char(CODE_BACKSPACE, 1'b1);
        send_char(8'h7E, 1'b1);
        wait_idle();
    endtask

    // Smallest, largest and zero screen sizes, and the unused register index.
    task automatic test_register_extremes();
        set_screen(1, 1, COLOR_BLACK);
        run_text(40);
        wait_idle();
        set_screen(255, 255, 24'hFF_FFFF);
        run_text(40);
        wait_idle();
        set_screen(0, 0, 24'($urandom));
        write_reg(REG_UNUSED, 24'($urandom));
        run_text(40);
        wait_idle();
    endtask

    task automatic test_random_screens();
        for (int p = 0; p < 4; p++)
        begin
            idle_en = ($urandom_range(0, 3) != 0);
            set_screen($urandom_range(1, 12), $urandom_range(1, 6), 24'($urandom));
            run_text(40);
            wait_idle();
        end
        idle_en = 1'b1;
    endtask

    // Long hold-off on the result side fills the block, then a full pause.
    task automatic test_backpressure();
        set_screen(3, 2, 24'($urandom));
        hold_len = 200;
        hold_req++;
        run_text(40);
        wait_idle();
        run_text(30);
        wait_idle();
    endtask

    // Leave the cursor far out on a wide screen, then shrink the screen under it.
    task automatic test_shrunk_cursor();
        set_screen(255, 255, 24'($urandom));
        send_char(CODE_NEWLINE, 1'b0);
        for (int i = 0; i < 270; i++)
            send_char(random_glyph(), i == 269);
        wait_idle();
        set_screen(5, 3, 24'($urandom));
        send_char(CODE_BACKSPACE, 1'b0);
        send_char(CODE_NEWLINE, 1'b0);
        send_char(random_glyph(), 1'b1);
        run_text(30);
        wait_idle();
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_full_rate();
        idle_en = 1'b0;
        set_screen($urandom_range(1, 8), $urandom_range(1, 4), 24'($urandom));
        run_text(80);
        wait_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_register_extremes();
        test_random_screens();
        test_backpressure();
        test_shrunk_cursor();
        test_full_rate();

        $display("Sent %0d characters (%0d acted on), checked %0d cell commands, %0d register writes.",
                 chars_sent, live_chars, cmds_checked, reg_writes);
        $display("Screens from zero and 1x1 up to 255x255, origin backspace, discards, wraps, scrolls, stalls.");
        if (mismatches == 0)
            $display("PASS text_console_cursor_controller");
        else
            $display("FAIL text_console_cursor_controller");
        $finish;
    end

endmodule
